>>> rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg: sinusoidal timestep embedding shared definitions
// Widths, fixed-point constants, the frequency table and the record types
// that travel down the embedding pipeline.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int CHANNELS = 320;
  localparam int HALF_CH  = CHANNELS / 2;
  localparam int IDX_W    = $clog2(HALF_CH);

  localparam int STEP_W   = 10;
  localparam int IDX_IN_W = 8;
  localparam int VAL_W    = 16;

  localparam int ENTRY_W  = 32;
  localparam int F_W      = 30;
  localparam int HPI_W    = 31;
  localparam int X_W      = 31;
  localparam int X2_W     = 32;
  localparam int T_W      = 31;
  localparam int P_W      = 32;
  localparam int Q0_W     = 32;
  localparam int SUM_W    = 34;
  localparam int Q14_W    = 15;
  localparam int DIV_W    = 8;
  localparam int RCP_W    = 32;

  localparam int NTERMS   = 7;
  localparam int NSTG     = 4 + 3 * NTERMS;

  localparam logic [63:0] LN10000_Q32 = (64'd9 << 32)
    + ((64'd210340371 << 32) / 64'd1000000000)
    + ((64'd976182736 << 32) / 64'd1000000000000000000);
  localparam logic [63:0] LN2_Q32 = (64'd0 << 32)
    + ((64'd693147180 << 32) / 64'd1000000000)
    + ((64'd559945309 << 32) / 64'd1000000000000000000);
  localparam logic [63:0] LN2PI_Q32 = (64'd1 << 32)
    + ((64'd837877066 << 32) / 64'd1000000000)
    + ((64'd409345483 << 32) / 64'd1000000000000000000);
  localparam logic [63:0] HALFPI_Q30 = (64'd1 << 30)
    + ((64'd570796326 << 30) / 64'd1000000000)
    + ((64'd794896619 << 30) / 64'd1000000000000000000);

  localparam logic [HPI_W-1:0] HALFPI = HPI_W'(HALFPI_Q30);
  localparam logic [T_W-1:0]   ONE_T  = T_W'(64'd1 << 30);

  // Divisors of the sine and cosine series terms and their truncated
  // reciprocals in 0.32 form.
  localparam logic [DIV_W-1:0] SIN_DIV [NTERMS] =
    '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
  localparam logic [DIV_W-1:0] COS_DIV [NTERMS] =
    '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
  localparam logic [RCP_W-1:0] SIN_RCP [NTERMS] = '{
    RCP_W'((64'd1 << 32) / 64'd6),   RCP_W'((64'd1 << 32) / 64'd20),
    RCP_W'((64'd1 << 32) / 64'd42),  RCP_W'((64'd1 << 32) / 64'd72),
    RCP_W'((64'd1 << 32) / 64'd110), RCP_W'((64'd1 << 32) / 64'd156),
    RCP_W'((64'd1 << 32) / 64'd210)};
  localparam logic [RCP_W-1:0] COS_RCP [NTERMS] = '{
    RCP_W'((64'd1 << 32) / 64'd2),   RCP_W'((64'd1 << 32) / 64'd12),
    RCP_W'((64'd1 << 32) / 64'd30),  RCP_W'((64'd1 << 32) / 64'd56),
    RCP_W'((64'd1 << 32) / 64'd90),  RCP_W'((64'd1 << 32) / 64'd132),
    RCP_W'((64'd1 << 32) / 64'd182)};

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    quad_t                    quad;
    logic                     oor;
    logic [X2_W-1:0]          x2;
    logic [T_W-1:0]           ts;
    logic [T_W-1:0]           tc;
    logic signed [SUM_W-1:0]  s;
    logic signed [SUM_W-1:0]  c;
  } ste_acc_t;

  typedef struct packed {
    logic [DIV_W-1:0] ds;
    logic [DIV_W-1:0] dc;
    logic [RCP_W-1:0] ms;
    logic [RCP_W-1:0] mc;
    logic             sub;
  } ste_coef_t;

  typedef struct packed {
    logic busy;
    logic spare;
  } ste_ostat_t;

  typedef logic [ENTRY_W-1:0] rom_t [HALF_CH];

  // Frequency over two pi as a 0.32 fraction of a turn, from exp(-y) built
  // with a Taylor series in Q32 and a power-of-two scale.
  function automatic logic [ENTRY_W-1:0] rom_entry(int idx);
    logic [63:0]        y;
    logic [63:0]        k;
    logic [63:0]        r;
    logic [63:0]        t;
    logic signed [63:0] e;
    y = (LN10000_Q32 * 64'(idx)) / 64'(HALF_CH) + LN2PI_Q32;
    k = y / LN2_Q32;
    r = y - k * LN2_Q32;
    t = 64'd1 << 32;
    e = $signed(t);
    t = ((t * r) >> 32) / 64'd1;  e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd2;  e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd3;  e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd4;  e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd5;  e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd6;  e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd7;  e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd8;  e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd9;  e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd10; e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd11; e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd12; e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd13; e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd14; e = e + $signed(t);
    t = ((t * r) >> 32) / 64'd15; e = e - $signed(t);
    t = ((t * r) >> 32) / 64'd16; e = e + $signed(t);
    if (e < 0) begin
      e = '0;
    end
    if (k == 64'd0 || k > 64'd40) begin
      return '0;
    end
    return ENTRY_W'(($unsigned(e) + (64'd1 << (k - 64'd1))) >> k);
  endfunction

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int i = 0; i < HALF_CH; i++) begin
      tbl[i] = rom_entry(i);
    end
    return tbl;
  endfunction

  localparam rom_t FREQ_ROM = build_rom();

endpackage

>>> rtl/ste_if.sv
// ----------------------------------------------------------------------------
// ste_if: embedding channel interfaces
// Valid/ready channels for timestep requests and embedding results.
// ----------------------------------------------------------------------------
interface ste_in_if;
  import ste_pkg::*;

  logic                valid;
  logic                ready;
  logic [STEP_W-1:0]   step_number;
  logic [IDX_IN_W-1:0] freq_index;

  modport source (output valid, output step_number, output freq_index, input ready);
  modport sink (input valid, input step_number, input freq_index, output ready);
endinterface

interface ste_out_if;
  import ste_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] cos_value;
  logic signed [VAL_W-1:0] sin_value;

  modport source (output valid, output cos_value, output sin_value, input ready);
  modport sink (input valid, input cos_value, input sin_value, output ready);
endinterface

>>> rtl/sinusoidal_timestep_embedding_top.sv
// ----------------------------------------------------------------------------
// sinusoidal_timestep_embedding_top: sinusoidal timestep embedding unit
// Returns Q2.14 cosine and sine of a timestep times a table frequency.
//
//   Channel    Direction  Payload                        Role
//   timestep   sink       step_number, freq_index        one request per transfer
//   embed      source     cos_value, sin_value           one result per request
//
// One request is taken every cycle while timestep.ready is high; a result
// passes through four front-end stages, seven series terms of three stages
// each (product, reciprocal product, correction and sum) and the output
// register. Reset clears all valid bits and the output buffer. When the output
// stalls, one more result goes to a spare entry and then the whole pipeline
// holds; timestep.ready is low exactly while the spare entry is full.
// ----------------------------------------------------------------------------
module sinusoidal_timestep_embedding_top (
  input  logic       clk,
  input  logic       rst,
  ste_in_if.sink     timestep,
  ste_out_if.source  embed
);
  import ste_pkg::*;

  logic            en;
  logic [NSTG-1:0] vld;
  ste_acc_t        acc [NTERMS+1];
  ste_coef_t       coef [NTERMS];
  ste_ostat_t      stat;

  assign en             = !stat.spare;
  assign timestep.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], timestep.valid};
    end
  end

  ste_phase u_phase (
    .clk         (clk),
    .en          (en),
    .step_number (timestep.step_number),
    .freq_index  (timestep.freq_index),
    .acc         (acc[0])
  );

  for (genvar g = 0; g < NTERMS; g++) begin : g_term
    assign coef[g].ds  = SIN_DIV[g];
    assign coef[g].dc  = COS_DIV[g];
    assign coef[g].ms  = SIN_RCP[g];
    assign coef[g].mc  = COS_RCP[g];
    assign coef[g].sub = ((g % 2) == 0);

    ste_term u_term (
      .clk     (clk),
      .en      (en),
      .coef    (coef[g]),
      .acc_in  (acc[g]),
      .acc_out (acc[g+1])
    );
  end

  ste_finish u_finish (
    .clk    (clk),
    .rst    (rst),
    .last_v (vld[NSTG-1]),
    .acc    (acc[NTERMS]),
    .embed  (embed),
    .stat   (stat)
  );

  a_spare_needs_result: assert property (@(posedge clk) disable iff (rst)
    stat.spare |-> (stat.busy && embed.valid))
    else $error("spare entry full while output register is empty");

  a_stall_fills_spare: assert property (@(posedge clk) disable iff (rst)
    (embed.valid && !embed.ready && vld[NSTG-1] && !stat.spare) |=> stat.spare)
    else $error("result leaving the pipeline was not buffered during a stall");

  a_spare_drains: assert property (@(posedge clk) disable iff (rst)
    (stat.spare && embed.ready) |=> (embed.valid && !stat.spare))
    else $error("spare entry did not move to the output register");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!(|vld) && !stat.spare && (embed.ready || !embed.valid)) |=> !embed.valid)
    else $error("result appeared with no request in flight");

endmodule

>>> rtl/ste_phase.sv
// ----------------------------------------------------------------------------
// ste_phase: phase front end
// Table lookup, phase product, quarter-turn angle in radians and its square,
// over four register stages.
// ----------------------------------------------------------------------------
module ste_phase (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ste_pkg::STEP_W-1:0]    step_number,
  input  logic [ste_pkg::IDX_IN_W-1:0]  freq_index,
  output ste_pkg::ste_acc_t             acc
);
  import ste_pkg::*;

  logic                 in_range;
  logic [IDX_W-1:0]     rd_idx;
  logic [STEP_W+ENTRY_W-1:0] phase_prod;
  logic [F_W+HPI_W-1:0] x_prod;
  logic [2*X_W-1:0]     x2_prod;

  logic [STEP_W-1:0]    s1_step;
  logic [ENTRY_W-1:0]   s1_entry;
  logic                 s1_oor;
  quad_t                s2_quad;
  logic [F_W-1:0]       s2_f;
  logic                 s2_oor;
  quad_t                s3_quad;
  logic [X_W-1:0]       s3_x;
  logic                 s3_oor;

  assign in_range   = 32'(freq_index) < 32'(HALF_CH);
  assign rd_idx     = in_range ? IDX_W'(freq_index) : '0;
  assign phase_prod = (STEP_W+ENTRY_W)'(s1_step) * (STEP_W+ENTRY_W)'(s1_entry);
  assign x_prod     = (F_W+HPI_W)'(s2_f) * (F_W+HPI_W)'(HALFPI);
  assign x2_prod    = (2*X_W)'(s3_x) * (2*X_W)'(s3_x);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_step  <= step_number;
      s1_entry <= FREQ_ROM[rd_idx];
      s1_oor   <= !in_range;

      s2_quad  <= quad_t'(phase_prod[31:30]);
      s2_f     <= phase_prod[F_W-1:0];
      s2_oor   <= s1_oor;

      s3_quad  <= s2_quad;
      s3_x     <= X_W'(x_prod >> 30);
      s3_oor   <= s2_oor;

      acc.quad <= s3_quad;
      acc.oor  <= s3_oor;
      acc.x2   <= X2_W'(x2_prod >> 30);
      acc.ts   <= T_W'(s3_x);
      acc.tc   <= ONE_T;
      acc.s    <= $signed(SUM_W'(s3_x));
      acc.c    <= $signed(SUM_W'(ONE_T));
    end
  end

endmodule

>>> rtl/ste_term.sv
// ----------------------------------------------------------------------------
// ste_term: one series term for sine and cosine
// Multiplies the previous terms by the squared angle, divides by the term's
// constant through a reciprocal product with a one-step correction, and
// updates both running sums, over three register stages.
// ----------------------------------------------------------------------------
module ste_term (
  input  logic               clk,
  input  logic               en,
  input  ste_pkg::ste_coef_t coef,
  input  ste_pkg::ste_acc_t  acc_in,
  output ste_pkg::ste_acc_t  acc_out
);
  import ste_pkg::*;

  ste_acc_t         a_acc;
  logic [P_W-1:0]   a_ps;
  logic [P_W-1:0]   a_pc;
  ste_acc_t         b_acc;
  logic [P_W-1:0]   b_ps;
  logic [P_W-1:0]   b_pc;
  logic [Q0_W-1:0]  b_qs;
  logic [Q0_W-1:0]  b_qc;
  logic [Q0_W-1:0]  qs;
  logic [Q0_W-1:0]  qc;

  function automatic logic [Q0_W-1:0] fix_quot(logic [Q0_W-1:0] q0, logic [P_W-1:0] p,
                                               logic [DIV_W-1:0] d);
    logic [P_W+DIV_W-1:0] rem;
    rem = (P_W+DIV_W)'(p) - (P_W+DIV_W)'(q0) * (P_W+DIV_W)'(d);
    return (rem >= (P_W+DIV_W)'(d)) ? q0 + Q0_W'(1) : q0;
  endfunction

  assign qs = fix_quot(b_qs, b_ps, coef.ds);
  assign qc = fix_quot(b_qc, b_pc, coef.dc);

  always_ff @(posedge clk) begin
    if (en) begin
      a_acc <= acc_in;
      a_ps  <= P_W'((64'(acc_in.ts) * 64'(acc_in.x2)) >> 30);
      a_pc  <= P_W'((64'(acc_in.tc) * 64'(acc_in.x2)) >> 30);

      b_acc <= a_acc;
      b_ps  <= a_ps;
      b_pc  <= a_pc;
      b_qs  <= Q0_W'((64'(a_ps) * 64'(coef.ms)) >> 32);
      b_qc  <= Q0_W'((64'(a_pc) * 64'(coef.mc)) >> 32);

      acc_out.quad <= b_acc.quad;
      acc_out.oor  <= b_acc.oor;
      acc_out.x2   <= b_acc.x2;
      acc_out.ts   <= T_W'(qs);
      acc_out.tc   <= T_W'(qc);
      acc_out.s    <= coef.sub ? b_acc.s - $signed(SUM_W'(qs)) : b_acc.s + $signed(SUM_W'(qs));
      acc_out.c    <= coef.sub ? b_acc.c - $signed(SUM_W'(qc)) : b_acc.c + $signed(SUM_W'(qc));
    end
  end

endmodule

>>> rtl/ste_finish.sv
// ----------------------------------------------------------------------------
// ste_finish: rounding, quadrant mapping and output buffer
// Clamps and rounds the series sums to Q2.14, maps them to the phase
// quadrant, and holds results in an output register with one spare entry.
// ----------------------------------------------------------------------------
module ste_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               last_v,
  input  ste_pkg::ste_acc_t  acc,
  ste_out_if.source          embed,
  output ste_pkg::ste_ostat_t stat
);
  import ste_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE_S = $signed(SUM_W'(64'd1 << 30));

  logic [Q14_W-1:0]        rc;
  logic [Q14_W-1:0]        rs;
  logic signed [VAL_W-1:0] cp;
  logic signed [VAL_W-1:0] sp;
  logic signed [VAL_W-1:0] cos_n;
  logic signed [VAL_W-1:0] sin_n;
  logic                    take;

  logic                    res_valid;
  logic signed [VAL_W-1:0] res_cos;
  logic signed [VAL_W-1:0] res_sin;
  logic                    spare_valid;
  logic signed [VAL_W-1:0] spare_cos;
  logic signed [VAL_W-1:0] spare_sin;

  function automatic logic [Q14_W-1:0] q14(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] cl;
    if (v < 0) begin
      cl = '0;
    end else if (v > ONE_S) begin
      cl = $unsigned(ONE_S);
    end else begin
      cl = $unsigned(v);
    end
    return Q14_W'((cl + SUM_W'(1 << 15)) >> 16);
  endfunction

  always_comb begin
    rc = q14(acc.c);
    rs = q14(acc.s);
    cp = $signed(VAL_W'(rc));
    sp = $signed(VAL_W'(rs));
    unique case (acc.quad)
      QUAD_0: begin
        cos_n = cp;
        sin_n = sp;
      end
      QUAD_1: begin
        cos_n = -sp;
        sin_n = cp;
      end
      QUAD_2: begin
        cos_n = -cp;
        sin_n = -sp;
      end
      QUAD_3: begin
        cos_n = sp;
        sin_n = -cp;
      end
      default: begin
        cos_n = '0;
        sin_n = '0;
      end
    endcase
    if (acc.oor) begin
      cos_n = '0;
      sin_n = '0;
    end
  end

  assign take = !res_valid || embed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (take) begin
      res_valid   <= spare_valid || last_v;
      spare_valid <= 1'b0;
    end else if (last_v && !spare_valid) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_cos <= spare_valid ? spare_cos : cos_n;
      res_sin <= spare_valid ? spare_sin : sin_n;
    end else if (!spare_valid) begin
      spare_cos <= cos_n;
      spare_sin <= sin_n;
    end
  end

  assign embed.valid     = res_valid;
  assign embed.cos_value = res_cos;
  assign embed.sin_value = res_sin;
  assign stat.busy       = res_valid;
  assign stat.spare      = spare_valid;

endmodule

>>> tb/ste_embed_check.sv
// ----------------------------------------------------------------------------
// ste_embed_check: result checker for the timestep embedding unit
// Watches both channels. On each request transfer it works out the expected
// Q2.14 cosine and sine from its own frequency function and series evaluation.
// Each result transfer is compared in order against the oldest expectation.
// ----------------------------------------------------------------------------
module ste_embed_check (
  input  logic clk,
  input  logic rst,
  ste_in_if    timestep,
  ste_out_if   embed,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ste_pkg::*;

  localparam logic [63:0] LOG_TENK = (64'd9 << 32)
    + ((64'd210340371 << 32) / 64'd1000000000)
    + ((64'd976182736 << 32) / 64'd1000000000000000000);
  localparam logic [63:0] LOG_TWO = ((64'd693147180 << 32) / 64'd1000000000)
    + ((64'd559945309 << 32) / 64'd1000000000000000000);
  localparam logic [63:0] LOG_TWO_PI = (64'd1 << 32)
    + ((64'd837877066 << 32) / 64'd1000000000)
    + ((64'd409345483 << 32) / 64'd1000000000000000000);
  localparam logic [63:0] HALF_PI_Q30 = (64'd1 << 30)
    + ((64'd570796326 << 30) / 64'd1000000000)
    + ((64'd794896619 << 30) / 64'd1000000000000000000);
  localparam longint UNIT_Q30 = 64'sd1 <<< 30;

  typedef struct packed {
    logic [STEP_W-1:0]       step;
    logic [IDX_IN_W-1:0]     idx;
    logic signed [VAL_W-1:0] cos_v;
    logic signed [VAL_W-1:0] sin_v;
  } embed_pair_t;

  embed_pair_t expected_q[$];
  int          fail_count = 0;
  int          pending_count = 0;
  int          result_no = 0;

  assign mismatches  = fail_count;
  assign outstanding = pending_count;

  // Frequency of the index over two pi, as a 0.32 fraction of a turn.
  function automatic logic [31:0] turn_rate(logic [IDX_IN_W-1:0] idx);
    logic [63:0] y;
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] t;
    longint      e;
    y = (LOG_TENK * 64'(idx)) / 64'(HALF_CH) + LOG_TWO_PI;
    k = y / LOG_TWO;
    r = y - k * LOG_TWO;
    t = 64'd1 << 32;
    e = longint'(t);
    for (int n = 1; n <= 16; n++) begin
      t = ((t * r) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        e -= longint'(t);
      end else begin
        e += longint'(t);
      end
    end
    if (e < 0) begin
      e = 0;
    end
    if (k == 64'd0 || k > 64'd40) begin
      return 32'd0;
    end
    return 32'((64'(e) + (64'd1 << (k - 64'd1))) >> k);
  endfunction

  function automatic int round_to_q14(longint v);
    if (v < 0) begin
      v = 0;
    end
    if (v > UNIT_Q30) begin
      v = UNIT_Q30;
    end
    return int'((v + 32768) >>> 16);
  endfunction

  function automatic void first_quadrant(input logic [29:0] f, output int s_q14,
                                         output int c_q14);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      s_acc;
    longint      c_acc;
    x  = (64'(f) * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'(UNIT_Q30);
    s_acc = longint'(x);
    c_acc = UNIT_Q30;
    for (int n = 1; n <= 7; n++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s_acc -= longint'(ts);
        c_acc -= longint'(tc);
      end else begin
        s_acc += longint'(ts);
        c_acc += longint'(tc);
      end
    end
    s_q14 = round_to_q14(s_acc);
    c_q14 = round_to_q14(c_acc);
  endfunction

  function automatic embed_pair_t predict_embedding(logic [STEP_W-1:0] s,
                                                    logic [IDX_IN_W-1:0] f);
    embed_pair_t p;
    logic [31:0] phase;
    int          sv;
    int          cv;
    p.step  = s;
    p.idx   = f;
    p.cos_v = '0;
    p.sin_v = '0;
    if (f >= HALF_CH) begin
      return p;
    end
    phase = 32'(64'(s) * 64'(turn_rate(f)));
    first_quadrant(phase[29:0], sv, cv);
    case (quad_t'(phase[31:30]))
      QUAD_0: begin
        p.cos_v = VAL_W'(cv);
        p.sin_v = VAL_W'(sv);
      end
      QUAD_1: begin
        p.cos_v = VAL_W'(-sv);
        p.sin_v = VAL_W'(cv);
      end
      QUAD_2: begin
        p.cos_v = VAL_W'(-cv);
        p.sin_v = VAL_W'(-sv);
      end
      default: begin
        p.cos_v = VAL_W'(sv);
        p.sin_v = VAL_W'(-cv);
      end
    endcase
    return p;
  endfunction

  always @(posedge clk) begin : watch
    embed_pair_t want;
    if (rst) begin
      expected_q.delete();
    end else begin
      if (timestep.valid && timestep.ready) begin
        expected_q.push_back(predict_embedding(timestep.step_number, timestep.freq_index));
      end
      if (embed.valid && embed.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("ERROR: result %0d with no request waiting: cos=%0d sin=%0d",
                     result_no, embed.cos_value, embed.sin_value);
          end
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (embed.cos_value !== want.cos_v || embed.sin_value !== want.sin_v) begin
            if (fail_count < 10) begin
              $display("ERROR: #%0d step %0d idx %0d: cos/sin expected %0d/%0d, got %0d/%0d",
                       result_no, want.step, want.idx, want.cos_v, want.sin_v,
                       embed.cos_value, embed.sin_value);
            end
            fail_count++;
          end
        end
        result_no++;
      end
    end
    pending_count = expected_q.size();
  end

endmodule

>>> tb/tb_sinusoidal_timestep_embedding_top.sv
// ----------------------------------------------------------------------------
// tb_sinusoidal_timestep_embedding_top: testbench for the embedding unit
// Drives directed corner requests and then random ones, with random gaps on
// the request side and random stalls on the result side until the last batch.
// A long result stall fills the pipeline; two pauses let every result drain.
// The checker beside the unit supplies the mismatch count for the verdict.
// ----------------------------------------------------------------------------
module tb_sinusoidal_timestep_embedding_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ste_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int N_DIRECTED  = 20;

  logic clk;
  logic rst;
  bit   gaps_enabled;
  bit   hold_req;
  int   mismatches;
  int   outstanding;

  logic [STEP_W-1:0]   corner_step [N_DIRECTED] = '{
    10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd1023, 10'd1023,
    10'd0, 10'd1, 10'd1023, 10'd512, 10'd341, 10'd682, 10'd1023, 10'd0, 10'd1023,
    10'd170};
  logic [IDX_IN_W-1:0] corner_index [N_DIRECTED] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd159,
    8'd159, 8'd159, 8'd1, 8'd80, 8'd128, 8'd100, 8'd160, 8'd255, 8'd255,
    8'd200};

  ste_in_if  timestep_ch ();
  ste_out_if embed_ch ();

  sinusoidal_timestep_embedding_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .timestep (timestep_ch),
    .embed    (embed_ch)
  );

  ste_embed_check i_check (
    .clk         (clk),
    .rst         (rst),
    .timestep    (timestep_ch),
    .embed       (embed_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sinusoidal_timestep_embedding_top test failed");
    $finish;
  end

  task automatic send_request(input logic [STEP_W-1:0] s, input logic [IDX_IN_W-1:0] f);
    int gap;
    @(negedge clk);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      timestep_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    timestep_ch.valid       <= 1'b1;
    timestep_ch.step_number <= s;
    timestep_ch.freq_index  <= f;
    do @(posedge clk); while (!timestep_ch.ready);
  endtask

  // Mostly valid indices, with a share beyond the table to hit the zero case.
  task automatic send_random_batch(input int count, input int hold_at);
    logic [IDX_IN_W-1:0] f;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) begin
        hold_req = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        f = IDX_IN_W'($urandom_range(0, HALF_CH - 1));
      end else begin
        f = IDX_IN_W'($urandom_range(HALF_CH, 255));
      end
      send_request(STEP_W'($urandom_range(0, 1023)), f);
    end
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    timestep_ch.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin : receiver
    int stall;
    embed_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        embed_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 7);
        embed_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        embed_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst                     = 1'b1;
    gaps_enabled            = 1'b1;
    hold_req                = 1'b0;
    timestep_ch.valid       = 1'b0;
    timestep_ch.step_number = '0;
    timestep_ch.freq_index  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < N_DIRECTED; n++) begin
      send_request(corner_step[n], corner_index[n]);
    end
    stop_and_drain();

    send_random_batch(300, 100);
    gaps_enabled = 1'b0;
    send_random_batch(100, -1);
    stop_and_drain();
    repeat (30) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("sinusoidal_timestep_embedding_top test passed");
    end else begin
      $display("sinusoidal_timestep_embedding_top test failed");
    end
    $finish;
  end

endmodule
